### rtl/assert_macros.svh
// Assertion macros used by the scope frame CRC16 encoder RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SFC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SFC_ASSERT_NEVER(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define SFC_ASSERT(name, clk, rst, prop, msg)
`define SFC_ASSERT_NEVER(name, clk, rst, expr, msg)
`endif
`endif

### rtl/sfc_pkg.sv
// Package for the scope frame CRC16 encoder: constants, status types, CRC step.
// No dependencies.
`timescale 1ns / 1ps
package sfc_pkg;

   localparam int CHANNELS_DEF = 4;
   localparam int SAMPLE_W     = 16;
   localparam int BYTE_W       = 8;
   localparam int QUEUE_DEPTH  = 2;
   localparam int COUNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
   } front_status_type;

   typedef struct packed {
      logic busy;
      logic pop;
   } back_status_type;

   // CRC-16/MODBUS, one byte LSB first
   function automatic logic [15:0] crc_add_byte(input logic [15:0] crc,
                                                input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### rtl/sfc_front.sv
// Front end of the frame encoder: takes sample requests into a small queue.
// Depends on sfc_pkg.
`timescale 1ns / 1ps
module sfc_front import sfc_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [CHANNELS*SAMPLE_W-1:0] req_tdata,
   output logic                         pop_valid,
   output logic [CHANNELS*SAMPLE_W-1:0] pop_data,
   input  logic                         pop_ready,
   output front_status_type             status
);
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int WORD_W = CHANNELS * SAMPLE_W;

   logic [WORD_W-1:0]  entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               push, pop;

   assign req_tready = (count_ff != COUNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = pop_valid && pop_ready;
   assign status.count = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_tdata;
      end
   end

endmodule

### rtl/sfc_back.sv
// Back end of the frame encoder: serializes one request into bytes, adds CRC.
// Depends on sfc_pkg.
`timescale 1ns / 1ps
module sfc_back import sfc_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         pop_valid,
   input  logic [CHANNELS*SAMPLE_W-1:0] pop_data,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [BYTE_W-1:0]            rsp_tdata,
   output logic                         rsp_tlast,
   output back_status_type              status
);
   localparam int WORD_W      = CHANNELS * SAMPLE_W;
   localparam int DATA_BYTES  = 2 * CHANNELS;
   localparam int FRAME_BYTES = DATA_BYTES + 2;
   localparam int IDX_W       = $clog2(FRAME_BYTES);

   logic [WORD_W-1:0] word_ff, word_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [15:0]       crc_ff, crc_in;
   logic              busy_ff, busy_in;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_data_ff, out_data_in;
   logic              out_last_ff, out_last_in;
   logic              advance, at_last, pop;

   assign advance = !out_valid_ff || rsp_tready;
   assign at_last = (idx_ff == IDX_W'(FRAME_BYTES - 1));
   assign pop     = pop_valid && (!busy_ff || (advance && at_last));

   assign rsp_tvalid  = out_valid_ff;
   assign rsp_tdata   = out_data_ff;
   assign rsp_tlast   = out_last_ff;
   assign status.busy = busy_ff;
   assign status.pop  = pop;

   always_comb begin
      word_in      = word_ff;
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      busy_in      = busy_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = busy_ff;
         out_last_in  = busy_ff && at_last;
         if (idx_ff < IDX_W'(DATA_BYTES)) begin
            out_data_in = word_ff[BYTE_W-1:0];
         end else if (idx_ff == IDX_W'(DATA_BYTES)) begin
            out_data_in = crc_ff[7:0];
         end else begin
            out_data_in = crc_ff[15:8];
         end
         if (busy_ff) begin
            if (idx_ff < IDX_W'(DATA_BYTES)) begin
               crc_in  = crc_add_byte(crc_ff, word_ff[BYTE_W-1:0]);
               word_in = word_ff >> BYTE_W;
            end
            idx_in = idx_ff + 1'b1;
            if (at_last) begin
               busy_in = 1'b0;
            end
         end
      end
      // next request loads when idle, or as the previous frame's last byte is registered
      if (pop) begin
         word_in = pop_data;
         idx_in  = '0;
         crc_in  = CRC_INIT;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      crc_ff      <= crc_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

endmodule

### rtl/scope_frame_crc16_encoder.sv
// Scope frame CRC16 encoder: a request of CHANNELS 16-bit samples becomes a
// 2*CHANNELS+2 byte frame of samples (low byte first) and a CRC-16/MODBUS
// (init 0xFFFF, reflected poly 0xA001, no final xor), low byte first; tlast
// marks the CRC high byte. One byte leaves per cycle while rsp_tready is high.
// A two-entry queue takes new requests while a frame is still going out; the
// serializer loads the next request as it registers the previous frame's last
// byte, so frames follow with no gap. The first byte of a request accepted into
// an empty block passes the queue entry, serializer word and output registers.
// Depends on sfc_pkg, sfc_front, sfc_back.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module scope_frame_crc16_encoder import sfc_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // sample_0, sample_1, ... sample_(CHANNELS-1), 16 bits each from bit 0
   input  logic [CHANNELS*SAMPLE_W-1:0] req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // frame_byte
   output logic [BYTE_W-1:0]            rsp_tdata,
   output logic                         rsp_tlast
);
   logic                         pop_valid;
   logic [CHANNELS*SAMPLE_W-1:0] pop_data;
   front_status_type             front_status;
   back_status_type              back_status;

   sfc_front #(.CHANNELS(CHANNELS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (back_status.pop),
      .status     (front_status)
   );

   sfc_back #(.CHANNELS(CHANNELS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .status     (back_status)
   );

   `SFC_ASSERT_NEVER(a_queue_bound, clock, reset, front_status.count > COUNT_W'(QUEUE_DEPTH), "queue overfilled")
   `SFC_ASSERT_NEVER(a_pop_empty, clock, reset, back_status.pop && front_status.count == '0, "pop from empty queue")
   `SFC_ASSERT(a_push_count, clock, reset, (req_tvalid && req_tready && !back_status.pop) |=> (front_status.count == $past(front_status.count) + 1'b1), "queue count missed a request")
   `SFC_ASSERT(a_pop_busy, clock, reset, back_status.pop |=> back_status.busy, "serializer idle after load")

endmodule

### test/tb_scope_frame_crc16_encoder.sv
// Self-checking testbench for scope_frame_crc16_encoder: sends sample requests,
// predicts each 10-byte frame with a bit-serial CRC-16/MODBUS model and checks it.
// Depends on sfc_pkg and the scope_frame_crc16_encoder RTL.
`timescale 1ns / 1ps
module tb_scope_frame_crc16_encoder;
   import sfc_pkg::*;

   localparam int CH        = CHANNELS_DEF;
   localparam int DATA_W    = CH * SAMPLE_W;
   localparam int FRAME_LEN = 2 * CH + 2;

   typedef struct {
      logic [BYTE_W-1:0] frame_byte;
      logic              last_byte;
   } frame_byte_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [BYTE_W-1:0] rsp_tdata;
   logic              rsp_tlast;

   frame_byte_type pending_frame_bytes[$];
   int             mismatch_count = 0;
   bit             traffic_gaps   = 1'b1;

   scope_frame_crc16_encoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("FAIL");
      $finish;
   end

   // CRC over the data stream one bit at a time; byte n is data[8n +: 8], so the
   // LSB-first bit order of the frame is simply bit 0 upward
   function automatic logic [15:0] modbus_crc(input logic [DATA_W-1:0] data);
      logic [15:0] crc;
      logic        feedback;
      crc = CRC_INIT;
      for (int i = 0; i < DATA_W; i++) begin
         feedback = crc[0] ^ data[i];
         crc      = crc >> 1;
         if (feedback) begin
            crc = crc ^ CRC_POLY;
         end
      end
      return crc;
   endfunction

   task automatic push_expected_frame(input logic [DATA_W-1:0] data);
      frame_byte_type fb;
      logic [15:0]    crc;
      crc = modbus_crc(data);
      for (int n = 0; n < FRAME_LEN; n++) begin
         if (n < 2 * CH) begin
            fb.frame_byte = data[n*BYTE_W +: BYTE_W];
         end else if (n == 2 * CH) begin
            fb.frame_byte = crc[7:0];
         end else begin
            fb.frame_byte = crc[15:8];
         end
         fb.last_byte = (n == FRAME_LEN - 1);
         pending_frame_bytes.push_back(fb);
      end
   endtask

   // valid is left high after acceptance; the next call lowers it only if it idles
   task automatic send_request(input logic [DATA_W-1:0] data);
      if (traffic_gaps) begin
         while ($urandom_range(99) < 32) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      push_expected_frame(data);
   endtask

   task automatic wait_frames_done();
      req_tvalid <= 1'b0;
      while (pending_frame_bytes.size() != 0) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] random_request();
      logic [DATA_W-1:0] data;
      for (int c = 0; c < CH; c++) begin
         data[c*SAMPLE_W +: SAMPLE_W] = random_sample();
      end
      return data;
   endfunction

   // full-scale, zero, sign boundaries and alternating bit patterns
   task automatic test_extremes();
      send_request({CH{16'h0000}});
      send_request({CH{16'hFFFF}});
      send_request({CH{16'h8000}});
      send_request({CH{16'h7FFF}});
      send_request({CH{16'h0001}});
      send_request({CH{16'h5555}});
      send_request({CH{16'hAAAA}});
      send_request({16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000});
      send_request({16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000});
      send_request({16'hFF00, 16'h00FF, 16'hFF00, 16'h00FF});
      send_request({16'h8001, 16'h4002, 16'h2004, 16'h1008});
      send_request({16'h0000, 16'h0000, 16'h0000, 16'h0080});
      wait_frames_done();
   endtask

   task automatic test_random_frames(input int count);
      for (int i = 0; i < count; i++) begin
         send_request(random_request());
      end
      wait_frames_done();
   endtask

   // no gaps on either side: requests and output ready are driven without holes
   task automatic test_back_to_back(input int count);
      traffic_gaps = 1'b0;
      for (int i = 0; i < count; i++) begin
         send_request(random_request());
      end
      wait_frames_done();
      traffic_gaps = 1'b1;
   endtask

   always @(posedge clock) begin
      rsp_tready <= !traffic_gaps || ($urandom_range(99) >= 32);
   end

   always @(posedge clock) begin
      frame_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_frame_bytes.size() == 0) begin
            $error("frame_byte: none expected, got %h (last %b)", rsp_tdata, rsp_tlast);
            mismatch_count++;
         end else begin
            want = pending_frame_bytes.pop_front();
            if (rsp_tdata !== want.frame_byte) begin
               $error("frame_byte: expected %h, got %h", want.frame_byte, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tlast !== want.last_byte) begin
               $error("last_byte: expected %b, got %b", want.last_byte, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_extremes();
      test_random_frames(70);
      test_back_to_back(30);
      test_random_frames(50);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
